### sv/csvfs_pkg.sv
// Package for the CSV field splitter: byte width, special bytes, the
// front-to-back command word and the back-end state type.
// No dependencies.
package csvfs_pkg;

  localparam int BYTE_W        = 8;
  localparam int FIELD_DEPTH_D = 32;
  localparam int CMDQ_DEPTH    = 4;

  localparam logic [BYTE_W-1:0] QUOTE_BYTE    = 8'h22;
  localparam logic [BYTE_W-1:0] DEFAULT_DELIM = 8'h2C;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_FIELD_END,
    CMD_LINE_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SEND,
    BK_EMPTY
  } back_state_t;

  // C whitespace: tab, newline, vertical tab, form feed, carriage return, space
  function automatic logic is_space(input logic [BYTE_W-1:0] b);
    return ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32);
  endfunction

endpackage

### sv/csvfs_ifs.sv
// Valid/ready channel interfaces for the CSV field splitter: text in,
// field bytes out. Depends on csvfs_pkg.
interface csvfs_text_if import csvfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              line_end;

  modport source (output valid, output text_byte, output line_end, input ready);
  modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface

interface csvfs_field_if import csvfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] field_byte;
  logic              byte_valid;
  logic              field_last;
  logic              line_last;
  logic              field_overflow;

  modport source (output valid, output field_byte, output byte_valid, output field_last,
                  output line_last, output field_overflow, input ready);
  modport sink   (input valid, input field_byte, input byte_valid, input field_last,
                  input line_last, input field_overflow, output ready);
endinterface

### sv/csvfs_front.sv
// Front end: accepts text words, tracks quoting and turns each word into
// at most one command for the back end. Depends on csvfs_pkg.
module csvfs_front import csvfs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_line_end,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output cmd_t              cmd
);

  logic [BYTE_W-1:0] delimiter;
  logic              quoted_mode, quoted_mode_next;
  logic              quote_pending, quote_pending_next;
  logic              line_nonempty, line_nonempty_next;
  logic              has_cmd;
  logic              quoted_eff;
  logic              accept;

  assign in_ready = cmd_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    quoted_mode_next   = quoted_mode;
    quote_pending_next = quote_pending;
    line_nonempty_next = line_nonempty;
    has_cmd            = 1'b0;
    cmd.kind           = CMD_STORE;
    cmd.data           = in_byte;
    quoted_eff         = quoted_mode;
    if (in_line_end) begin
      if (line_nonempty) begin
        has_cmd  = 1'b1;
        cmd.kind = CMD_LINE_END;
      end
      quoted_mode_next   = 1'b0;
      quote_pending_next = 1'b0;
      line_nonempty_next = 1'b0;
    end else begin
      line_nonempty_next = 1'b1;
      if (quote_pending && (in_byte == QUOTE_BYTE)) begin
        // doubled quote: store one literal quote, stay quoted
        quote_pending_next = 1'b0;
        has_cmd            = 1'b1;
      end else begin
        if (quote_pending) begin
          quote_pending_next = 1'b0;
          quoted_eff         = 1'b0;
        end
        quoted_mode_next = quoted_eff;
        if (in_byte == QUOTE_BYTE) begin
          if (quoted_eff) begin
            quote_pending_next = 1'b1;
          end else begin
            quoted_mode_next = 1'b1;
          end
        end else if ((in_byte == delimiter) && !quoted_eff) begin
          has_cmd  = 1'b1;
          cmd.kind = CMD_FIELD_END;
        end else begin
          has_cmd = 1'b1;
        end
      end
    end
  end

  assign cmd_valid = accept && has_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter     <= DEFAULT_DELIM;
      quoted_mode   <= 1'b0;
      quote_pending <= 1'b0;
      line_nonempty <= 1'b0;
    end else begin
      if (cfg_we) begin
        delimiter <= cfg_wdata;
      end
      if (accept) begin
        quoted_mode   <= quoted_mode_next;
        quote_pending <= quote_pending_next;
        line_nonempty <= line_nonempty_next;
      end
    end
  end

endmodule

### sv/csvfs_cmd_fifo.sv
// Short command queue between the front and back ends.
// Depends on csvfs_pkg.
module csvfs_cmd_fifo import csvfs_pkg::*; #(
  parameter int DEPTH = CMDQ_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic not_full,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic not_empty,
  output cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_full  = (count != CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head_cmd  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/csvfs_back.sv
// Back end: stores field bytes, tracks the trimmed span and replays it
// through the output register. Depends on csvfs_pkg.
module csvfs_back import csvfs_pkg::*; #(
  parameter int FIELD_DEPTH = FIELD_DEPTH_D
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  cmd_t               cmd,
  csvfs_field_if.source      fields
);

  localparam int IDX_W = $clog2(FIELD_DEPTH);
  localparam int CNT_W = $clog2(FIELD_DEPTH + 1);

  logic [BYTE_W-1:0] field_store [FIELD_DEPTH];
  logic [BYTE_W-1:0] rd_data;

  back_state_t       state, state_next;
  logic [CNT_W-1:0]  fill_count;
  logic [IDX_W-1:0]  first_idx, last_idx, rd_idx;
  logic              content_seen, overflow_flag, line_flag;
  logic              out_valid, out_free, load, fin, store_ok, do_store;

  assign out_free = !out_valid || fields.ready;
  assign fin      = (rd_idx == last_idx);
  assign store_ok = (fill_count < CNT_W'(FIELD_DEPTH));
  assign do_store = cmd_pop && (cmd.kind == CMD_STORE);

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    load       = 1'b0;
    case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.kind != CMD_STORE) begin
            state_next = content_seen ? BK_READ : BK_EMPTY;
          end
        end
      end
      BK_READ: state_next = BK_SEND;
      BK_SEND: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = fin ? BK_IDLE : BK_READ;
        end
      end
      BK_EMPTY: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Field store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_store && store_ok) begin
      field_store[fill_count[IDX_W-1:0]] <= cmd.data;
    end
    rd_data <= field_store[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      fill_count    <= '0;
      first_idx     <= '0;
      last_idx      <= '0;
      content_seen  <= 1'b0;
      overflow_flag <= 1'b0;
      line_flag     <= 1'b0;
      rd_idx        <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (do_store) begin
        if (store_ok) begin
          if (!is_space(cmd.data)) begin
            if (!content_seen) begin
              first_idx    <= fill_count[IDX_W-1:0];
              content_seen <= 1'b1;
            end
            last_idx <= fill_count[IDX_W-1:0];
          end
          fill_count <= fill_count + 1'b1;
        end else begin
          overflow_flag <= 1'b1;
        end
      end else if (cmd_pop) begin
        line_flag <= (cmd.kind == CMD_LINE_END);
        rd_idx    <= first_idx;
      end
      if (load && (state == BK_SEND) && !fin) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
        if ((state == BK_EMPTY) || fin) begin
          fill_count    <= '0;
          first_idx     <= '0;
          last_idx      <= '0;
          content_seen  <= 1'b0;
          overflow_flag <= 1'b0;
        end
      end else if (fields.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fields.field_overflow <= overflow_flag;
      if (state == BK_EMPTY) begin
        fields.field_byte <= '0;
        fields.byte_valid <= 1'b0;
        fields.field_last <= 1'b1;
        fields.line_last  <= line_flag;
      end else begin
        fields.field_byte <= rd_data;
        fields.byte_valid <= 1'b1;
        fields.field_last <= fin;
        fields.line_last  <= fin && line_flag;
      end
    end
  end

  assign fields.valid = out_valid;

endmodule

### sv/csv_field_splitter.sv
// Top level of the CSV field splitter: front end, command queue, back end.
// Depends on csvfs_pkg, csvfs_ifs, csvfs_front, csvfs_cmd_fifo, csvfs_back.
//
//   channel   dir  handshake          payload
//   text      in   valid / ready      text_byte[7:0], line_end
//   fields    out  valid / ready      field_byte[7:0], byte_valid, field_last,
//                                     line_last, field_overflow
//   cfg       in   cfg_we             cfg_wdata[7:0] = delimiter byte
//
// Flow: the front takes one text word per cycle while the command queue has
// room. The back pops stored bytes and field ends from the queue only while
// idle, then replays each trimmed byte as a registered store read followed
// by an output load, waiting while the output register is full; a field
// that trims to nothing gives one empty field word.
// Reset: synchronous, active high; clears quoting state, counters and the
// queue, and sets the delimiter to a comma. The field store is not cleared.
// Stalls: the output register holds a word until taken; the back end waits on
// it while the queue keeps absorbing input, and the front stalls only when
// the queue is full.
module csv_field_splitter import csvfs_pkg::*; #(
  parameter int FIELD_DEPTH = FIELD_DEPTH_D
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_wdata,
  csvfs_text_if.sink        text,
  csvfs_field_if.source     fields
);

  // front to queue
  logic push_valid, q_not_full;
  cmd_t push_cmd;
  // queue to back
  logic q_not_empty, q_pop;
  cmd_t head_cmd;

  // Classify each word: store a byte, end a field or end a line
  csvfs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (text.valid),
    .in_ready    (text.ready),
    .in_byte     (text.text_byte),
    .in_line_end (text.line_end),
    .cmd_valid   (push_valid),
    .cmd_ready   (q_not_full),
    .cmd         (push_cmd)
  );

  // Decouple the two sides so each may stall on its own
  csvfs_cmd_fifo #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .not_full  (q_not_full),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  // Store, trim and replay fields
  csvfs_back #(
    .FIELD_DEPTH (FIELD_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd_pop   (q_pop),
    .cmd       (head_cmd),
    .fields    (fields)
  );

endmodule

### bench/tb_csv_field_splitter.sv
// Self-checking bench for csv_field_splitter: random and directed CSV text in,
// trimmed field words out, checked against a field tracker class.
// Depends on csvfs_pkg, csvfs_ifs and the splitter RTL.
`timescale 1ns / 100ps

module tb_csv_field_splitter;
  import csvfs_pkg::*;

  localparam int HALF_PERIOD = 4;    // 8 ns clock
  localparam int DRAIN_PAUSE = 64;   // back end may still be storing bytes
  localparam int QUIET_LIMIT = 4000; // cycles with no word moved on either side
  localparam int LONG_HOLD   = 400;  // receiver hold-off that fills the block
  localparam int PHASE_ITEMS = 4;    // least number of random text words per phase

  typedef struct packed {
    logic [BYTE_W-1:0] fbyte;
    logic              bvalid;
    logic              flast;
    logic              llast;
    logic              fovf;
  } field_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] tbyte;
    logic              eol;
  } text_word_t;

  // Tracks quoting, the field store and trimming, and holds the field words
  // still owed by the block, oldest first.
  class field_tracker;
    logic [BYTE_W-1:0] store [FIELD_DEPTH_D];
    logic [5:0]        fill;
    logic [4:0]        first_idx;
    logic [4:0]        last_idx;
    bit                quoted;
    bit                quote_held;
    bit                seen;
    bit                line_open;
    bit                lost_bytes;
    logic [BYTE_W-1:0] delim;
    field_word_t       expected_words[$];
    int                mismatches;

    function new();
      delim      = DEFAULT_DELIM;
      quoted     = 0;
      quote_held = 0;
      line_open  = 0;
      mismatches = 0;
      clear_field();
    endfunction

    function void set_delim(logic [BYTE_W-1:0] d);
      delim = d;
    endfunction

    function bit is_blank(logic [BYTE_W-1:0] b);
      return (b >= 8'd9 && b <= 8'd13) || b == 8'd32;
    endfunction

    function void clear_field();
      fill       = '0;
      first_idx  = '0;
      last_idx   = '0;
      seen       = 0;
      lost_bytes = 0;
    endfunction

    function void keep_byte(logic [BYTE_W-1:0] b);
      if (fill < FIELD_DEPTH_D) begin
        store[fill] = b;
        if (!is_blank(b)) begin
          if (!seen) begin
            first_idx = fill[4:0];
            seen      = 1;
          end
          last_idx = fill[4:0];
        end
        fill++;
      end else begin
        lost_bytes = 1;
      end
    endfunction

    function void close_field(bit line_final);
      field_word_t w;
      if (seen) begin
        for (int i = first_idx; i <= last_idx; i++) begin
          w.fbyte  = store[i];
          w.bvalid = 1'b1;
          w.flast  = (i == last_idx);
          w.llast  = (i == last_idx) && line_final;
          w.fovf   = lost_bytes;
          expected_words.insert(expected_words.size(), w);
        end
      end else begin
        w = '{fbyte: '0, bvalid: 1'b0, flast: 1'b1, llast: line_final, fovf: lost_bytes};
        expected_words.insert(expected_words.size(), w);
      end
      clear_field();
    endfunction

    function void take_text(logic [BYTE_W-1:0] b, logic eol);
      if (eol) begin
        if (line_open) begin
          close_field(1);
          quoted     = 0;
          quote_held = 0;
          line_open  = 0;
        end
        return;
      end
      line_open = 1;
      if (quote_held) begin
        quote_held = 0;
        if (b == QUOTE_BYTE) begin
          keep_byte(QUOTE_BYTE);
          return;
        end
        quoted = 0;
      end
      if (b == QUOTE_BYTE) begin
        if (quoted) quote_held = 1;
        else quoted = 1;
      end else if (b == delim && !quoted) begin
        close_field(0);
      end else begin
        keep_byte(b);
      end
    endfunction

    function void check_word(field_word_t got);
      field_word_t want;
      if (expected_words.size() == 0) begin
        $error("field word with none expected: field_byte %0h", got.fbyte);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      if (got.fbyte !== want.fbyte) begin
        $error("field_byte: expected %0h, got %0h", want.fbyte, got.fbyte);
        mismatches++;
      end
      if (got.bvalid !== want.bvalid) begin
        $error("byte_valid: expected %0b, got %0b", want.bvalid, got.bvalid);
        mismatches++;
      end
      if (got.flast !== want.flast) begin
        $error("field_last: expected %0b, got %0b", want.flast, got.flast);
        mismatches++;
      end
      if (got.llast !== want.llast) begin
        $error("line_last: expected %0b, got %0b", want.llast, got.llast);
        mismatches++;
      end
      if (got.fovf !== want.fovf) begin
        $error("field_overflow: expected %0b, got %0b", want.fovf, got.fovf);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [BYTE_W-1:0] cfg_wdata;

  csvfs_text_if  text_ch();
  csvfs_field_if field_ch();

  csv_field_splitter u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .text     (text_ch),
    .fields   (field_ch)
  );

  field_tracker      tracker = new();
  text_word_t        stim[$];
  logic [BYTE_W-1:0] cur_delim = DEFAULT_DELIM;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  bit                hold_go = 0;

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Receiver: drop ready at random, or hold it low for one long stretch once
  // asked, so that the command queue fills and the text side stalls.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left     = 0;
    hold_done     = 0;
    field_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        field_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        field_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // Monitor and watchdog: sample both handshakes at the rising edge, feed
  // accepted text words to the tracker and check accepted field words. Give
  // up once nothing has moved for too long.
  initial begin
    int          quiet;
    bit          took_text;
    bit          took_word;
    field_word_t got;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      took_text = !rst && text_ch.valid && text_ch.ready;
      took_word = !rst && field_ch.valid && field_ch.ready;
      if (took_text) tracker.take_text(text_ch.text_byte, text_ch.line_end);
      if (took_word) begin
        got.fbyte  = field_ch.field_byte;
        got.bvalid = field_ch.byte_valid;
        got.flast  = field_ch.field_last;
        got.llast  = field_ch.line_last;
        got.fovf   = field_ch.field_overflow;
        tracker.check_word(got);
      end
      quiet = (took_text || took_word) ? 0 : quiet + 1;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---- stimulus building ----

  function automatic logic [BYTE_W-1:0] blank_byte();
    int r;
    r = $urandom_range(14, 9);
    return (r == 14) ? 8'd32 : 8'(r);
  endfunction

  // Any byte that carries no quoting or splitting meaning; bias to blanks so
  // trimming gets plenty of work.
  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do begin
      if ($urandom_range(3, 0) == 0) b = blank_byte();
      else b = 8'($urandom_range(255, 0));
    end while (b == QUOTE_BYTE || b == cur_delim);
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] quoted_byte();
    logic [BYTE_W-1:0] b;
    do b = 8'($urandom_range(255, 0)); while (b == QUOTE_BYTE);
    return b;
  endfunction

  // Append one text word to the stimulus queue.
  function automatic void add_word(input logic [BYTE_W-1:0] b, input logic eol);
    text_word_t w;
    w.tbyte = b;
    w.eol   = eol;
    stim.insert(stim.size(), w);
  endfunction

  task automatic push_text(input logic [BYTE_W-1:0] b);
    add_word(b, 1'b0);
  endtask

  // The byte alongside a line end should be ignored, so make it random.
  task automatic push_eol();
    add_word(8'($urandom), 1'b1);
  endtask

  // One field: empty, plain with blank padding, or quoted with doubled
  // quotes, delimiters and blanks inside and maybe a stray byte after.
  task automatic add_field();
    int kind;
    kind = $urandom_range(9, 0);
    if (kind == 0) return;
    if (kind <= 5) begin
      repeat ($urandom_range(2, 0)) push_text(blank_byte());
      repeat ($urandom_range(6, 1)) push_text(plain_byte());
      repeat ($urandom_range(2, 0)) push_text(blank_byte());
    end else begin
      repeat ($urandom_range(1, 0)) push_text(blank_byte());
      push_text(QUOTE_BYTE);
      repeat ($urandom_range(6, 0)) begin
        case ($urandom_range(5, 0))
          0: begin
            push_text(QUOTE_BYTE);
            push_text(QUOTE_BYTE);
          end
          1: push_text(cur_delim);
          2: push_text(blank_byte());
          default: push_text(quoted_byte());
        endcase
      end
      // leave the quote open now and then; the line end closes it
      if ($urandom_range(5, 0) != 0) push_text(QUOTE_BYTE);
      if ($urandom_range(3, 0) == 0) push_text(plain_byte());
    end
  endtask

  task automatic add_line();
    int nf;
    nf = $urandom_range(3, 1);
    for (int f = 0; f < nf; f++) begin
      if (f != 0) push_text(cur_delim);
      add_field();
    end
    push_eol();
  endtask

  // Broken input: loose quotes, delimiters, line ends and any byte at all.
  task automatic add_noise();
    repeat ($urandom_range(5, 1)) begin
      case ($urandom_range(9, 0))
        0: push_eol();
        1: push_text(QUOTE_BYTE);
        2: push_text(cur_delim);
        default: push_text(8'($urandom_range(255, 0)));
      endcase
    end
  endtask

  // A field that spills over the store, then enough plain bytes behind it to
  // fill the command queue while that field is replayed.
  task automatic add_long_line();
    repeat (FIELD_DEPTH_D + 1) push_text(plain_byte());
    push_text(cur_delim);
    repeat (CMDQ_DEPTH + 1) push_text(plain_byte());
    push_eol();
  endtask

  // Directed lines, comma delimiter.
  task automatic add_directed();
    // empty line with a junk byte alongside the line end: no output
    add_word(8'hFF, 1'b1);
    // byte extremes as one-byte fields
    push_text(8'h00);
    push_text(cur_delim);
    push_text(8'hFF);
    push_eol();
    // two fields of blanks only: each trims to an empty field
    push_text(8'h09);
    push_text(cur_delim);
    push_text(8'h0D);
    push_eol();
    // delimiter and doubled quote inside quotes, blanks inside quotes trimmed
    push_text(QUOTE_BYTE);
    push_text(8'h20);
    push_text("x");
    push_text(cur_delim);
    push_text(QUOTE_BYTE);
    push_text(QUOTE_BYTE);
    push_text(8'h20);
    push_text(QUOTE_BYTE);
    push_eol();
    // closing quote still pending when the line ends
    push_text(QUOTE_BYTE);
    push_text("a");
    push_text(QUOTE_BYTE);
    push_eol();
    // byte after a closing quote carries on the field unquoted
    push_text(QUOTE_BYTE);
    push_text("b");
    push_text(QUOTE_BYTE);
    push_text("c");
    push_eol();
  endtask

  // ---- driving ----

  // Offer each queued text word, idling at random between words, and hold
  // it until the block takes it.
  task automatic send_all();
    text_word_t w;
    while (stim.size() != 0) begin
      w = stim.pop_front();
      while ($urandom_range(99, 0) < send_idle_pct) begin
        text_ch.valid <= 1'b0;
        @(negedge clk);
      end
      text_ch.valid     <= 1'b1;
      text_ch.text_byte <= w.tbyte;
      text_ch.line_end  <= w.eol;
      do @(posedge clk); while (!text_ch.ready);
      @(negedge clk);
    end
    text_ch.valid <= 1'b0;
  endtask

  // Wait for every owed word, then give the back end time to finish any
  // stores that produce no output.
  task automatic wait_drained();
    while (tracker.pending() != 0) @(negedge clk);
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  task automatic write_delim(input logic [BYTE_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_delim = d;
    tracker.set_delim(d);
  endtask

  // One phase: settle, set the delimiter and idling, build the words, send.
  // Always finish on a line end so that the block drains completely.
  task automatic run_phase(input logic [BYTE_W-1:0] d, input int snd_pct, input int rcv_pct,
                           input bit directed, input bit with_long, input bit with_hold);
    int target;
    wait_drained();
    write_delim(d);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    if (directed) add_directed();
    if (with_long) add_long_line();
    target = stim.size() + PHASE_ITEMS;
    while (stim.size() < target) begin
      if ($urandom_range(4, 0) == 0) add_noise();
      else add_line();
    end
    push_eol();
    if (with_hold) hold_go = 1;
    send_all();
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    text_ch.valid     = 1'b0;
    text_ch.text_byte = '0;
    text_ch.line_end  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender idles a little, receiver a lot
    run_phase(DEFAULT_DELIM, 17, 70, 1, 0, 0);
    run_phase(8'h00, 17, 70, 0, 0, 0);
    // the other way round
    run_phase(8'hFF, 70, 17, 0, 0, 0);
    run_phase(QUOTE_BYTE, 70, 17, 0, 0, 0);
    // no idling, but a spilling field under one long receiver hold-off;
    // space as delimiter
    run_phase(8'h20, 0, 0, 0, 1, 1);

    wait_drained();
    if (tracker.pending() != 0) begin
      $error("%0d field words never arrived", tracker.pending());
      tracker.mismatches++;
    end
    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
